// ===== rtl/srs_pkg.sv =====
package srs_pkg;

    localparam int SPEED_W    = 16;
    localparam int CFG_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int TIMER_BITS_DEF = 16;

    localparam logic [3:0] ZERO_LIMIT_BUMP   = 4'd2;
    localparam logic [3:0] ZERO_LIMIT_NOBUMP = 4'd10;
    localparam logic [3:0] REG_ZERO_LIMIT    = 4'd2;
    localparam logic [2:0] BUMP_MAX          = 3'd3;
    localparam logic [3:0] REG_COUNT_FAST    = 4'd7;
    localparam logic [3:0] REG_COUNT_SLOW    = 4'd4;

    localparam logic [CFG_W-1:0] FAST_SPIN_RESET      = 16'd80;
    localparam logic [CFG_W-1:0] SPINUP_TIMEOUT_RESET = 16'd6000;
    localparam logic [CFG_W-1:0] REG_TIMEOUT_RESET    = 16'd12000;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_POLL  = 2'd1,
        OP_TICK  = 2'd2
    } srs_op_t;

    typedef enum logic [2:0] {
        ST_BUSY         = 3'd0,
        ST_SPINUP_DONE  = 3'd1,
        ST_REGULATED    = 3'd2,
        ST_READ_FAIL    = 3'd3,
        ST_BUMP_FAIL    = 3'd4,
        ST_TIMEOUT      = 3'd5,
        ST_SET_REJECTED = 3'd6
    } srs_status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SPINUP = 2'd1,
        PH_QUICK  = 2'd2,
        PH_REG    = 2'd3
    } srs_phase_t;

    typedef enum logic [1:0] {
        IL_NOT_ARMED = 2'd0,
        IL_READY     = 2'd2
    } srs_interlock_t;

    typedef enum logic [1:0] {
        REG_FAST_SPIN      = 2'd0,
        REG_SPINUP_TIMEOUT = 2'd1,
        REG_REG_TIMEOUT    = 2'd2
    } srs_reg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [SPEED_W-1:0] target_speed;
        logic               bump_enable;
        logic               set_accepted;
        logic [SPEED_W-1:0] measured_speed;
        logic               read_failed;
        logic               in_regulation;
    } srs_in_t;

    typedef struct packed {
        srs_status_t        status;
        srs_phase_t         phase;
        logic               bump_request;
        logic               spin_wait;
        srs_interlock_t     interlock_state;
        logic [SPEED_W-1:0] reported_speed;
    } srs_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] fast_spin_threshold;
        logic [CFG_W-1:0] spinup_timeout_ticks;
        logic [CFG_W-1:0] regulate_timeout_ticks;
    } srs_cfg_t;

    // supervisor state apart from the tick timer
    typedef struct packed {
        srs_phase_t         phase;
        logic [SPEED_W-1:0] held_target;
        logic               held_bump_enable;
        logic [3:0]         zero_count;
        logic [2:0]         bump_count;
        logic [3:0]         regulated_count;
        logic               expired;
        srs_interlock_t     interlock;
        logic               wait_flag;
        logic [SPEED_W-1:0] last_speed;
    } srs_state_t;

endpackage

// ===== rtl/spinner_regulation_supervisor_top.sv =====
// Spinner regulation supervisor. One transaction is accepted per clock cycle
// while the result output is not stalled; each start, poll or tick transaction
// yields exactly one result (the input register feeds the result register
// through the state update). The rate is set by the supervisor state update
// between the two registers. Configuration registers (APB, byte
// addresses 0x0, 0x4, 0x8):
// fast spin threshold, spin-up timeout and regulation timeout in ticks, each
// 16 bits; write them only while the block is idle. There are no memories
// and no start-up sweep.
module spinner_regulation_supervisor_top #(
    parameter int TIMER_BITS = srs_pkg::TIMER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  srs_pkg::srs_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output srs_pkg::srs_out_t                  m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [srs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    srs_pkg::srs_cfg_t      cfg_reg;
    srs_pkg::srs_in_t       in_data_reg;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    srs_pkg::srs_out_t      out_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    srs_pkg::srs_state_t    state_reg;
    srs_pkg::srs_state_t    state_next;
    logic [TIMER_BITS-1:0]  timer_reg;
    logic [TIMER_BITS-1:0]  timer_next;
    srs_pkg::srs_out_t      result;
    srs_pkg::srs_reg_idx_t  reg_idx;
    logic                   advance;
    logic                   cfg_write;

    srs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .in_data    (in_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .timer      (timer_reg),
        .state_next (state_next),
        .timer_next (timer_next),
        .result     (result)
    );

    // held transaction moves on when the result register is free or being drained
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);
    assign m_valid        = out_valid_reg;
    assign m_data         = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase            <= srs_pkg::PH_IDLE;
            state_reg.held_target      <= '0;
            state_reg.held_bump_enable <= 1'b0;
            state_reg.zero_count       <= '0;
            state_reg.bump_count       <= '0;
            state_reg.regulated_count  <= '0;
            state_reg.expired          <= 1'b0;
            state_reg.interlock        <= srs_pkg::IL_NOT_ARMED;
            state_reg.wait_flag        <= 1'b0;
            state_reg.last_speed       <= '0;
            timer_reg                  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            timer_reg <= timer_next;
        end
    end

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = srs_pkg::srs_reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_spin_threshold    <= srs_pkg::FAST_SPIN_RESET;
            cfg_reg.spinup_timeout_ticks   <= srs_pkg::SPINUP_TIMEOUT_RESET;
            cfg_reg.regulate_timeout_ticks <= srs_pkg::REG_TIMEOUT_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                srs_pkg::REG_FAST_SPIN:
                    cfg_reg.fast_spin_threshold <= pwdata[srs_pkg::CFG_W-1:0];
                srs_pkg::REG_SPINUP_TIMEOUT:
                    cfg_reg.spinup_timeout_ticks <= pwdata[srs_pkg::CFG_W-1:0];
                srs_pkg::REG_REG_TIMEOUT:
                    cfg_reg.regulate_timeout_ticks <= pwdata[srs_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            srs_pkg::REG_FAST_SPIN:
                prdata = srs_pkg::APB_DATA_W'(cfg_reg.fast_spin_threshold);
            srs_pkg::REG_SPINUP_TIMEOUT:
                prdata = srs_pkg::APB_DATA_W'(cfg_reg.spinup_timeout_ticks);
            srs_pkg::REG_REG_TIMEOUT:
                prdata = srs_pkg::APB_DATA_W'(cfg_reg.regulate_timeout_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/srs_core.sv =====
module srs_core #(
    parameter int TIMER_BITS = srs_pkg::TIMER_BITS_DEF
) (
    input  srs_pkg::srs_in_t       in_data,
    input  srs_pkg::srs_cfg_t      cfg,
    input  srs_pkg::srs_state_t    state,
    input  logic [TIMER_BITS-1:0]  timer,
    output srs_pkg::srs_state_t    state_next,
    output logic [TIMER_BITS-1:0]  timer_next,
    output srs_pkg::srs_out_t      result
);

    localparam int CMP_W = (TIMER_BITS > srs_pkg::CFG_W) ? TIMER_BITS : srs_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    srs_pkg::srs_status_t        status;
    logic                        bump;
    logic [3:0]                  zc;
    logic [2:0]                  bc;
    logic [3:0]                  rc;
    logic [3:0]                  zero_limit;
    logic [3:0]                  reg_max;
    logic [srs_pkg::CFG_W-1:0]   lim;
    logic [TIMER_BITS-1:0]       timer_inc;
    logic                        leave;
    logic                        leave_arm;

    always_comb begin
        state_next = state;
        timer_next = timer;
        status     = srs_pkg::ST_BUSY;
        bump       = 1'b0;
        leave      = 1'b0;
        leave_arm  = 1'b0;
        zc         = state.zero_count;
        bc         = state.bump_count;
        rc         = state.regulated_count;
        zero_limit = state.held_bump_enable ? srs_pkg::ZERO_LIMIT_BUMP
                                            : srs_pkg::ZERO_LIMIT_NOBUMP;
        reg_max    = (state.held_target >= cfg.fast_spin_threshold) ? srs_pkg::REG_COUNT_FAST
                                                                    : srs_pkg::REG_COUNT_SLOW;
        lim        = (state.phase == srs_pkg::PH_SPINUP) ? cfg.spinup_timeout_ticks
                                                         : cfg.regulate_timeout_ticks;
        timer_inc  = timer + TIMER_BITS'(timer != TIMER_MAX);

        case (in_data.op)
            srs_pkg::OP_START: begin
                state_next.held_target      = in_data.target_speed;
                state_next.held_bump_enable = in_data.bump_enable;
                state_next.zero_count       = '0;
                state_next.bump_count       = '0;
                state_next.regulated_count  = '0;
                state_next.expired          = 1'b0;
                timer_next                  = '0;
                state_next.interlock        = srs_pkg::IL_NOT_ARMED;
                state_next.wait_flag        = 1'b0;
                if (!in_data.set_accepted) begin
                    status           = srs_pkg::ST_SET_REJECTED;
                    state_next.phase = srs_pkg::PH_QUICK;
                end else if (in_data.target_speed == '0) begin
                    status           = srs_pkg::ST_SPINUP_DONE;
                    state_next.phase = srs_pkg::PH_QUICK;
                end else begin
                    state_next.phase = srs_pkg::PH_SPINUP;
                end
            end
            srs_pkg::OP_TICK: begin
                if ((state.phase == srs_pkg::PH_SPINUP || state.phase == srs_pkg::PH_REG)
                        && !state.expired) begin
                    timer_next = timer_inc;
                    // saturated timer counts as expired too
                    state_next.expired = (CMP_W'(timer_inc) >= CMP_W'(lim))
                                         || (timer_inc == TIMER_MAX);
                end
            end
            srs_pkg::OP_POLL: begin
                case (state.phase)
                    srs_pkg::PH_SPINUP: begin
                        if (in_data.read_failed) begin
                            status           = srs_pkg::ST_READ_FAIL;
                            state_next.phase = srs_pkg::PH_QUICK;
                        end else begin
                            state_next.last_speed = in_data.measured_speed;
                            if (in_data.measured_speed != '0) begin
                                status           = srs_pkg::ST_SPINUP_DONE;
                                state_next.phase = srs_pkg::PH_QUICK;
                            end else begin
                                zc = state.zero_count + 4'd1;
                                if (zc > zero_limit) begin
                                    if (!state.held_bump_enable) begin
                                        status = srs_pkg::ST_BUMP_FAIL;
                                    end else begin
                                        bc = state.bump_count + 3'd1;
                                        if (bc > srs_pkg::BUMP_MAX) begin
                                            status = srs_pkg::ST_BUMP_FAIL;
                                        end else begin
                                            bump = 1'b1;
                                            zc   = '0;
                                        end
                                    end
                                end
                                if (status == srs_pkg::ST_BUSY && state.expired) begin
                                    status = srs_pkg::ST_TIMEOUT;
                                end
                                if (status != srs_pkg::ST_BUSY) begin
                                    state_next.phase = srs_pkg::PH_QUICK;
                                end
                                state_next.zero_count = zc;
                                state_next.bump_count = bc;
                            end
                        end
                    end
                    srs_pkg::PH_QUICK: begin
                        if (in_data.in_regulation && !in_data.read_failed
                                && in_data.measured_speed == state.held_target) begin
                            state_next.interlock = srs_pkg::IL_READY;
                            status               = srs_pkg::ST_REGULATED;
                            state_next.phase     = srs_pkg::PH_IDLE;
                        end else begin
                            state_next.zero_count      = '0;
                            state_next.bump_count      = '0;
                            state_next.regulated_count = '0;
                            state_next.expired         = 1'b0;
                            timer_next                 = '0;
                            state_next.wait_flag       = 1'b1;
                            state_next.phase           = srs_pkg::PH_REG;
                        end
                    end
                    srs_pkg::PH_REG: begin
                        if (in_data.read_failed) begin
                            status    = srs_pkg::ST_READ_FAIL;
                            leave     = 1'b1;
                            leave_arm = 1'b1;
                        end else begin
                            state_next.last_speed = in_data.measured_speed;
                            if (state.held_target != '0) begin
                                if (in_data.in_regulation) rc = rc + 4'd1;
                                if (in_data.measured_speed == '0) zc = zc + 4'd1;
                            end else if (in_data.measured_speed == '0) begin
                                rc = rc + 4'd1;
                            end
                            if (zc > srs_pkg::REG_ZERO_LIMIT) begin
                                if (!state.held_bump_enable) begin
                                    // bump not allowed: exit leaves the interlock unarmed
                                    status = srs_pkg::ST_BUMP_FAIL;
                                    leave  = 1'b1;
                                end else begin
                                    bc = state.bump_count + 3'd1;
                                    if (bc > srs_pkg::BUMP_MAX) begin
                                        status    = srs_pkg::ST_BUMP_FAIL;
                                        leave     = 1'b1;
                                        leave_arm = 1'b1;
                                    end else begin
                                        bump = 1'b1;
                                        zc   = '0;
                                    end
                                end
                            end
                            if (status == srs_pkg::ST_BUSY && state.expired) begin
                                status    = srs_pkg::ST_TIMEOUT;
                                leave     = 1'b1;
                                leave_arm = 1'b1;
                            end
                            if (status == srs_pkg::ST_BUSY && rc > reg_max) begin
                                status    = srs_pkg::ST_REGULATED;
                                leave     = 1'b1;
                                leave_arm = 1'b1;
                            end
                            state_next.zero_count      = zc;
                            state_next.bump_count      = bc;
                            state_next.regulated_count = rc;
                        end
                        if (leave) begin
                            state_next.phase     = srs_pkg::PH_IDLE;
                            state_next.wait_flag = 1'b0;
                        end
                        if (leave_arm) begin
                            state_next.interlock = srs_pkg::IL_READY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.status          = status;
        result.phase           = state_next.phase;
        result.bump_request    = bump;
        result.spin_wait       = state_next.wait_flag;
        result.interlock_state = state_next.interlock;
        result.reported_speed  = state_next.last_speed;
    end

endmodule

// ===== rtl/srs_checker.sv =====
module srs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input srs_pkg::srs_out_t m_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a regulated outcome always arms the interlock
    a_reg_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == srs_pkg::ST_REGULATED
            |-> m_data.interlock_state == srs_pkg::IL_READY)
        else $error("regulated without interlock armed");

    // spin wait only while regulating
    a_wait_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.spin_wait |-> m_data.phase == srs_pkg::PH_REG)
        else $error("spin wait outside regulation");

    // a bump comes with a busy, timeout or regulated result on the same transaction
    a_bump_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bump_request
            |-> m_data.status == srs_pkg::ST_BUSY || m_data.status == srs_pkg::ST_TIMEOUT
                || m_data.status == srs_pkg::ST_REGULATED)
        else $error("bump with a final status");

endmodule

bind spinner_regulation_supervisor_top srs_checker u_srs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
